### design/dcfb_pkg.sv
// Shared types, codes and constants of the contention backoff engine.
package dcfb_pkg;

  // Field and register widths.
  localparam int CW_BITS        = 10;
  localparam int TIME_BITS      = 16;
  localparam int IFS_BITS       = 16;
  localparam int SLOT_BITS      = 12;
  localparam int RETRY_BITS     = 4;
  localparam int CMD_BITS       = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  // Width used for comparing idle time against interframe spaces.
  localparam int CMP_BITS = (TIME_BITS > IFS_BITS) ? TIME_BITS : IFS_BITS;

  // Width of the unclamped contention window, (cw_min + 1) << retry.
  localparam int WIN_BITS = CW_BITS + 1 + (2 ** RETRY_BITS) - 1;

  // Register values after reset.
  localparam logic [IFS_BITS-1:0]  IFS_RESET  = IFS_BITS'(34);
  localparam logic [IFS_BITS-1:0]  EIFS_RESET = IFS_BITS'(94);
  localparam logic [CW_BITS-1:0]   CWMIN_RESET = CW_BITS'(15);
  localparam logic [CW_BITS-1:0]   CWMAX_RESET = CW_BITS'(1023);
  localparam logic [SLOT_BITS-1:0] SLOT_RESET = SLOT_BITS'(9);

  // Contention states.
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DEFER    = 3'd1,
    ST_WAIT_IFS = 3'd2,
    ST_BACKOFF  = 3'd3,
    ST_TRANSMIT = 3'd4
  } state_t;

  // Request commands.
  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK     = 3'd0,
    CMD_START    = 3'd1,
    CMD_MEDIUM   = 3'd2,
    CMD_TX_DONE  = 3'd3,
    CMD_FRAME_RX = 3'd4
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IFS   = 3'd0,
    REG_EIFS  = 3'd1,
    REG_CWMIN = 3'd2,
    REG_CWMAX = 3'd3,
    REG_SLOT  = 3'd4
  } cfg_reg_t;

  // Configuration as seen by the engine.
  typedef struct packed {
    logic [IFS_BITS-1:0]  ifs_ticks;
    logic [IFS_BITS-1:0]  eifs_ticks;
    logic [CW_BITS-1:0]   cw_min;
    logic [CW_BITS-1:0]   cw_max;
    logic [SLOT_BITS-1:0] slot_ticks;
  } cfg_t;

  // One request.
  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic                  medium_free;
    logic [RETRY_BITS-1:0] retry_count;
    logic [CW_BITS-1:0]    random_value;
    logic                  fcs_ok;
  } req_t;

  // One result.
  typedef struct packed {
    state_t               cur_state;
    logic                 tx_start;
    logic                 tx_done;
    logic [CW_BITS-1:0]   slots_remaining;
  } res_t;

endpackage

### design/dcfb_cfg_regs.sv
// Configuration registers of the contention backoff engine.
module dcfb_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dcfb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dcfb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output dcfb_pkg::cfg_t                      cfg
);

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ifs_ticks  <= dcfb_pkg::IFS_RESET;
      cfg.eifs_ticks <= dcfb_pkg::EIFS_RESET;
      cfg.cw_min     <= dcfb_pkg::CWMIN_RESET;
      cfg.cw_max     <= dcfb_pkg::CWMAX_RESET;
      cfg.slot_ticks <= dcfb_pkg::SLOT_RESET;
    end else if (cfg_write) begin
      case (dcfb_pkg::cfg_reg_t'(cfg_index))
        dcfb_pkg::REG_IFS:   cfg.ifs_ticks  <= cfg_wdata[dcfb_pkg::IFS_BITS-1:0];
        dcfb_pkg::REG_EIFS:  cfg.eifs_ticks <= cfg_wdata[dcfb_pkg::IFS_BITS-1:0];
        dcfb_pkg::REG_CWMIN: cfg.cw_min     <= cfg_wdata[dcfb_pkg::CW_BITS-1:0];
        dcfb_pkg::REG_CWMAX: cfg.cw_max     <= cfg_wdata[dcfb_pkg::CW_BITS-1:0];
        dcfb_pkg::REG_SLOT:  cfg.slot_ticks <= cfg_wdata[dcfb_pkg::SLOT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### design/dcfb_engine.sv
// Contention state machine with its timers and the next-state logic for one request.
module dcfb_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  dcfb_pkg::req_t req,
  input  dcfb_pkg::cfg_t cfg,
  output dcfb_pkg::res_t res
);

  localparam logic [dcfb_pkg::TIME_BITS-1:0] IDLE_MAX = '1;

  dcfb_pkg::state_t                 state, state_next;
  logic                             link_free, link_free_next;
  logic [dcfb_pkg::TIME_BITS-1:0]   idle_time, idle_time_next;
  logic [dcfb_pkg::IFS_BITS-1:0]    ifs_left, ifs_left_next;
  logic [dcfb_pkg::IFS_BITS-1:0]    eifs_left, eifs_left_next;
  logic [dcfb_pkg::CW_BITS-1:0]     slots_left, slots_left_next;
  logic [dcfb_pkg::SLOT_BITS-1:0]   slot_phase, slot_phase_next;
  logic                             eifs_pending, eifs_pending_next;

  logic [dcfb_pkg::TIME_BITS-1:0]   idle_inc;
  logic [dcfb_pkg::IFS_BITS-1:0]    ifs_dec, eifs_dec;
  logic [dcfb_pkg::CW_BITS-1:0]     slots_dec;
  logic [dcfb_pkg::SLOT_BITS-1:0]   slot_len, phase_inc;
  logic [dcfb_pkg::CMP_BITS-1:0]    idle_cmp, ifs_cmp, eifs_cmp;
  logic                             ifs_short, eifs_short;
  logic [dcfb_pkg::CMP_BITS-1:0]    ifs_diff, eifs_diff;
  logic [dcfb_pkg::WIN_BITS-1:0]    win_raw, win;
  logic [dcfb_pkg::CW_BITS-1:0]     slots_drawn;

  // Counter steps and compares shared by the command paths.
  always_comb begin
    idle_inc  = (idle_time == IDLE_MAX) ? idle_time : idle_time + 1'b1;
    eifs_dec  = (eifs_left != '0) ? eifs_left - 1'b1 : eifs_left;
    ifs_dec   = (ifs_left != '0) ? ifs_left - 1'b1 : ifs_left;
    slots_dec = (slots_left != '0) ? slots_left - 1'b1 : slots_left;
    slot_len  = (cfg.slot_ticks == '0) ? dcfb_pkg::SLOT_BITS'(1) : cfg.slot_ticks;
    phase_inc = slot_phase + 1'b1;
    idle_cmp  = dcfb_pkg::CMP_BITS'(idle_time);
    ifs_cmp   = dcfb_pkg::CMP_BITS'(cfg.ifs_ticks);
    eifs_cmp  = dcfb_pkg::CMP_BITS'(cfg.eifs_ticks);
    ifs_short  = idle_cmp < ifs_cmp;
    eifs_short = idle_cmp < eifs_cmp;
    ifs_diff  = ifs_cmp - idle_cmp;
    eifs_diff = eifs_cmp - idle_cmp;
  end

  // Contention window, clamped to cw_max, masks the random draw.
  always_comb begin
    win_raw = ((dcfb_pkg::WIN_BITS'(cfg.cw_min) + 1'b1) << req.retry_count) - 1'b1;
    win     = (win_raw > dcfb_pkg::WIN_BITS'(cfg.cw_max)) ?
              dcfb_pkg::WIN_BITS'(cfg.cw_max) : win_raw;
    slots_drawn = req.random_value & win[dcfb_pkg::CW_BITS-1:0];
  end

  // Next state and timer values for the request at hand.
  always_comb begin
    state_next        = state;
    link_free_next    = link_free;
    idle_time_next    = idle_time;
    ifs_left_next     = ifs_left;
    eifs_left_next    = eifs_left;
    slots_left_next   = slots_left;
    slot_phase_next   = slot_phase;
    eifs_pending_next = eifs_pending;
    case (dcfb_pkg::cmd_t'(req.command))
      dcfb_pkg::CMD_TICK: begin
        idle_time_next = idle_inc;
        eifs_left_next = eifs_dec;
        case (state)
          dcfb_pkg::ST_WAIT_IFS: begin
            ifs_left_next = ifs_dec;
            if (ifs_dec == '0 && eifs_dec == '0) begin
              slot_phase_next = '0;
              state_next = (slots_left == '0) ? dcfb_pkg::ST_TRANSMIT
                                              : dcfb_pkg::ST_BACKOFF;
            end
          end
          dcfb_pkg::ST_BACKOFF: begin
            if (phase_inc >= slot_len) begin
              slot_phase_next = '0;
              slots_left_next = slots_dec;
              if (slots_dec == '0) begin
                state_next = dcfb_pkg::ST_TRANSMIT;
              end
            end else begin
              slot_phase_next = phase_inc;
            end
          end
          default: begin
          end
        endcase
      end
      dcfb_pkg::CMD_START: begin
        if (state == dcfb_pkg::ST_IDLE) begin
          slots_left_next = slots_drawn;
          if (!link_free) begin
            state_next = dcfb_pkg::ST_DEFER;
          end else if (ifs_short || (eifs_pending && eifs_short)) begin
            // Interframe spaces are shortened by the idle time already seen.
            state_next    = dcfb_pkg::ST_WAIT_IFS;
            ifs_left_next = ifs_short ? ifs_diff[dcfb_pkg::IFS_BITS-1:0] : '0;
            if (eifs_pending && eifs_short) begin
              eifs_left_next = eifs_diff[dcfb_pkg::IFS_BITS-1:0];
            end
            eifs_pending_next = 1'b0;
          end else begin
            state_next = dcfb_pkg::ST_TRANSMIT;
          end
        end
      end
      dcfb_pkg::CMD_MEDIUM: begin
        link_free_next = req.medium_free;
        idle_time_next = '0;
        if (state == dcfb_pkg::ST_DEFER && req.medium_free) begin
          // Idle time is cleared here, so the full spaces are loaded.
          state_next    = dcfb_pkg::ST_WAIT_IFS;
          ifs_left_next = cfg.ifs_ticks;
          if (eifs_pending && cfg.eifs_ticks != '0) begin
            eifs_left_next = cfg.eifs_ticks;
          end
          eifs_pending_next = 1'b0;
        end else if (state == dcfb_pkg::ST_WAIT_IFS && !req.medium_free) begin
          ifs_left_next = '0;
          state_next    = dcfb_pkg::ST_DEFER;
        end else if (state == dcfb_pkg::ST_BACKOFF && !req.medium_free) begin
          // The partial slot is dropped; full slots stay counted.
          slot_phase_next = '0;
          state_next      = dcfb_pkg::ST_DEFER;
        end
      end
      dcfb_pkg::CMD_TX_DONE: begin
        if (state == dcfb_pkg::ST_TRANSMIT) begin
          state_next = dcfb_pkg::ST_IDLE;
        end
      end
      dcfb_pkg::CMD_FRAME_RX: begin
        eifs_pending_next = !req.fcs_ok;
      end
      default: begin
      end
    endcase
  end

  // Result of the request, taken from the transition.
  always_comb begin
    res.cur_state       = state_next;
    res.tx_start        = (state != dcfb_pkg::ST_TRANSMIT) &&
                          (state_next == dcfb_pkg::ST_TRANSMIT);
    res.tx_done         = (state == dcfb_pkg::ST_TRANSMIT) &&
                          (state_next == dcfb_pkg::ST_IDLE);
    res.slots_remaining = slots_left_next;
  end

  // State and timer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dcfb_pkg::ST_IDLE;
      link_free    <= 1'b0;
      idle_time    <= '0;
      ifs_left     <= '0;
      eifs_left    <= '0;
      slots_left   <= '0;
      slot_phase   <= '0;
      eifs_pending <= 1'b0;
    end else if (advance) begin
      state        <= state_next;
      link_free    <= link_free_next;
      idle_time    <= idle_time_next;
      ifs_left     <= ifs_left_next;
      eifs_left    <= eifs_left_next;
      slots_left   <= slots_left_next;
      slot_phase   <= slot_phase_next;
      eifs_pending <= eifs_pending_next;
    end
  end

endmodule

### design/dcf_contention_backoff_core.sv
// Top level of the CSMA/CA contention backoff engine.
// A request is held in the request register and its result then enters the result
// register when that register is free or being emptied; a stalled result holds the
// request register. Throughput: one request per cycle while the result side does not
// stall, set by the single pass through the engine between the two registers.
// Reset (synchronous, active high) returns the engine to idle with a busy medium,
// clears all timers and empties both registers; configuration takes its defaults.
module dcf_contention_backoff_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dcfb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dcfb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dcfb_pkg::CMD_BITS-1:0]       command,
  input  logic                                medium_free,
  input  logic [dcfb_pkg::RETRY_BITS-1:0]     retry_count,
  input  logic [dcfb_pkg::CW_BITS-1:0]        random_value,
  input  logic                                fcs_ok,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          cur_state,
  output logic                                tx_start,
  output logic                                tx_done,
  output logic [dcfb_pkg::CW_BITS-1:0]        slots_remaining
);

  dcfb_pkg::cfg_t cfg;
  dcfb_pkg::req_t req_q;
  logic           req_valid;
  dcfb_pkg::res_t res, res_q;
  logic           advance;

  dcfb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dcfb_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req_q),
    .cfg     (cfg),
    .res     (res)
  );

  // A held request moves on when the result register is free or being emptied.
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q.command      <= command;
      req_q.medium_free  <= medium_free;
      req_q.retry_count  <= retry_count;
      req_q.random_value <= random_value;
      req_q.fcs_ok       <= fcs_ok;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign cur_state       = res_q.cur_state;
  assign tx_start        = res_q.tx_start;
  assign tx_done         = res_q.tx_done;
  assign slots_remaining = res_q.slots_remaining;

endmodule

### design/dcfb_checker.sv
// Port-level checks of the contention backoff engine, bound to the top level.
module dcfb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [2:0]                   cur_state,
  input logic                         tx_start,
  input logic                         tx_done,
  input logic [dcfb_pkg::CW_BITS-1:0] slots_remaining
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cur_state) && $stable(tx_start)
      && $stable(tx_done) && $stable(slots_remaining))
    else $error("stalled result changed");

  // A transmit start always reports the transmit state.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_start |-> cur_state == 3'(dcfb_pkg::ST_TRANSMIT))
    else $error("tx_start outside transmit");

  // A finished transmission always reports idle, and never with a start.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_done |-> cur_state == 3'(dcfb_pkg::ST_IDLE) && !tx_start)
    else $error("tx_done without return to idle");

  // With the result register empty a request is always taken.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty result register");

  // Reset empties the result register.
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind dcf_contention_backoff_core dcfb_checker u_checker (.*);

### test/dcf_contention_backoff_core_tb.sv
`timescale 1ns / 100ps
// Testbench for the contention backoff engine: steered random requests checked by a predictor.
module dcf_contention_backoff_core_tb;
  import dcfb_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASES         = 9;
  localparam int PHASE_REQS     = 210;
  localparam int HIGH_REQS      = 60;
  localparam int MAX_REPORTS    = 50;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED      = 3'd7;
  localparam logic [CMD_BITS-1:0]       CMD_RESERVED_LO = 3'd5;
  localparam logic [CMD_BITS-1:0]       CMD_RESERVED_HI = 3'd7;

  // Block inputs, all known from time zero.
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic [CMD_BITS-1:0]       command = '0;
  logic                      medium_free = 1'b0;
  logic [RETRY_BITS-1:0]     retry_count = '0;
  logic [CW_BITS-1:0]        random_value = '0;
  logic                      fcs_ok = 1'b0;
  logic                      out_ready = 1'b0;

  // Block outputs.
  logic               in_ready;
  logic               out_valid;
  logic [2:0]         cur_state;
  logic               tx_start;
  logic               tx_done;
  logic [CW_BITS-1:0] slots_remaining;

  // Idling controls, changed per phase.
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  // Predicts the contention engine and holds the results still to come.
  class contention_scoreboard;
    logic [IFS_BITS-1:0]  ifs_len;
    logic [IFS_BITS-1:0]  eifs_len;
    logic [CW_BITS-1:0]   cwmin;
    logic [CW_BITS-1:0]   cwmax;
    logic [SLOT_BITS-1:0] slot_len;
    state_t               st;
    bit                   link_up;
    logic [TIME_BITS-1:0] idle_span;
    logic [IFS_BITS-1:0]  ifs_cnt;
    logic [IFS_BITS-1:0]  eifs_cnt;
    logic [CW_BITS-1:0]   slots;
    logic [SLOT_BITS-1:0] phase;
    bit                   eifs_armed;
    res_t                 expected_q[$];
    int                   errors;
    int                   results_seen;

    function new();
      ifs_len      = IFS_RESET;
      eifs_len     = EIFS_RESET;
      cwmin        = CWMIN_RESET;
      cwmax        = CWMAX_RESET;
      slot_len     = SLOT_RESET;
      st           = ST_IDLE;
      link_up      = 1'b0;
      idle_span    = '0;
      ifs_cnt      = '0;
      eifs_cnt     = '0;
      slots        = '0;
      phase        = '0;
      eifs_armed   = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_IFS:   ifs_len = val;
        REG_EIFS:  eifs_len = val;
        REG_CWMIN: cwmin = val[CW_BITS-1:0];
        REG_CWMAX: cwmax = val[CW_BITS-1:0];
        REG_SLOT:  slot_len = val[SLOT_BITS-1:0];
        default: ;
      endcase
    endfunction

    // The interframe space is shortened by the idle time already seen.
    function void enter_wait_ifs();
      st = ST_WAIT_IFS;
      ifs_cnt = (ifs_len > idle_span) ? ifs_len - idle_span : '0;
      if (eifs_armed && eifs_len > idle_span) eifs_cnt = eifs_len - idle_span;
      eifs_armed = 1'b0;
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(req_t r);
      logic [WIN_BITS-1:0]  win;
      logic [SLOT_BITS-1:0] slot_eff;
      bit                   tx;
      bit                   done;
      res_t                 want;
      tx = 1'b0;
      done = 1'b0;
      slot_eff = (slot_len == 0) ? SLOT_BITS'(1) : slot_len;
      case (r.command)
        CMD_TICK: begin
          if (idle_span != '1) idle_span++;
          if (eifs_cnt != 0) eifs_cnt--;
          if (st == ST_WAIT_IFS) begin
            if (ifs_cnt != 0) ifs_cnt--;
            // Both spaces over: backoff, or transmit straight away with no slots.
            if (ifs_cnt == 0 && eifs_cnt == 0) begin
              phase = '0;
              if (slots == 0) begin
                st = ST_TRANSMIT;
                tx = 1'b1;
              end else begin
                st = ST_BACKOFF;
              end
            end
          end else if (st == ST_BACKOFF) begin
            phase++;
            if (phase >= slot_eff) begin
              phase = '0;
              if (slots != 0) slots--;
              if (slots == 0) begin
                st = ST_TRANSMIT;
                tx = 1'b1;
              end
            end
          end
        end
        CMD_START: begin
          if (st == ST_IDLE) begin
            win = (WIN_BITS'(cwmin) + 1'b1) << r.retry_count;
            win = win - 1'b1;
            if (win > WIN_BITS'(cwmax)) win = WIN_BITS'(cwmax);
            slots = r.random_value & win[CW_BITS-1:0];
            if (!link_up) begin
              st = ST_DEFER;
            end else if (idle_span < ifs_len || (eifs_armed && idle_span < eifs_len)) begin
              enter_wait_ifs();
            end else begin
              st = ST_TRANSMIT;
              tx = 1'b1;
            end
          end
        end
        CMD_MEDIUM: begin
          link_up = r.medium_free;
          idle_span = '0;
          if (st == ST_DEFER && r.medium_free) begin
            enter_wait_ifs();
          end else if (st == ST_WAIT_IFS && !r.medium_free) begin
            ifs_cnt = '0;
            st = ST_DEFER;
          end else if (st == ST_BACKOFF && !r.medium_free) begin
            phase = '0;
            st = ST_DEFER;
          end
        end
        CMD_TX_DONE: begin
          if (st == ST_TRANSMIT) begin
            st = ST_IDLE;
            done = 1'b1;
          end
        end
        CMD_FRAME_RX: eifs_armed = !r.fcs_ok;
        default: ;
      endcase
      want.cur_state       = st;
      want.tx_start        = tx;
      want.tx_done         = done;
      want.slots_remaining = slots;
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: result %0d, %s: got %0d, expected %0d",
                 $time, results_seen, what, got_v, want_v);
    endtask

    // Compares one result with the oldest expectation.
    task check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected, state", 32'(got.cur_state), '0);
      end else begin
        want = expected_q.pop_front();
        if (got.cur_state !== want.cur_state)
          report_mismatch("cur_state", 32'(got.cur_state), 32'(want.cur_state));
        if (got.tx_start !== want.tx_start)
          report_mismatch("tx_start", 32'(got.tx_start), 32'(want.tx_start));
        if (got.tx_done !== want.tx_done)
          report_mismatch("tx_done", 32'(got.tx_done), 32'(want.tx_done));
        if (got.slots_remaining !== want.slots_remaining)
          report_mismatch("slots_remaining", 32'(got.slots_remaining),
                          32'(want.slots_remaining));
      end
    endtask
  endclass

  contention_scoreboard sb = new();

  dcf_contention_backoff_core u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .medium_free     (medium_free),
    .retry_count     (retry_count),
    .random_value    (random_value),
    .fcs_ok          (fcs_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cur_state       (cur_state),
    .tx_start        (tx_start),
    .tx_done         (tx_done),
    .slots_remaining (slots_remaining)
  );

  // Free-running clock.
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // The result side stalls in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk) begin : result_monitor
    res_t got;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got = {cur_state, tx_start, tx_done, slots_remaining};
      sb.check_result(got);
    end
  end

  // Ends the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL dcf_contention_backoff_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t make_req(logic [CMD_BITS-1:0] cmd, logic free,
                                    logic [RETRY_BITS-1:0] retry, logic [CW_BITS-1:0] rnd,
                                    logic fcs);
    req_t r;
    r.command      = cmd;
    r.medium_free  = free;
    r.retry_count  = retry;
    r.random_value = rnd;
    r.fcs_ok       = fcs;
    return r;
  endfunction

  // Random request, steered by the predicted state so that sequences get deep.
  function automatic req_t pick_request();
    req_t        r;
    int unsigned roll;
    r = make_req(CMD_TICK, 1'($urandom_range(0, 1)), RETRY_BITS'($urandom),
                 CW_BITS'($urandom), 1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 99);
    if (sb.st == ST_TRANSMIT && roll < 60) begin
      r.command = CMD_TX_DONE;
    end else if (sb.st == ST_IDLE && roll < 25) begin
      r.command = CMD_START;
    end else if (sb.st == ST_DEFER && roll < 20) begin
      r.command = CMD_MEDIUM;
      r.medium_free = 1'b1;
    end else if ((sb.st == ST_WAIT_IFS || sb.st == ST_BACKOFF) && roll < 85) begin
      r.command = CMD_TICK;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        r.command = CMD_TICK;
      end else if (roll < 80) begin
        r.command = CMD_MEDIUM;
        r.medium_free = ($urandom_range(0, 99) < 65);
      end else if (roll < 87) begin
        r.command = CMD_FRAME_RX;
      end else if (roll < 92) begin
        r.command = CMD_START;
      end else if (roll < 96) begin
        r.command = CMD_TX_DONE;
      end else begin
        r.command = CMD_BITS'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      end
    end
    return r;
  endfunction

  // Presents one request and holds it until accepted, then maybe idles.
  task automatic send_request(req_t r);
    in_valid     <= 1'b1;
    command      <= r.command;
    medium_free  <= r.medium_free;
    retry_count  <= r.retry_count;
    random_value <= r.random_value;
    fcs_ok       <= r.fcs_ok;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(r);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stops sending until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all registers, then an index past the last one, which must be ignored.
  task automatic write_config(cfg_t c);
    logic [CFG_DATA_BITS-1:0] vals [5];
    logic [CFG_DATA_BITS-1:0] junk;
    vals[REG_IFS]   = c.ifs_ticks;
    vals[REG_EIFS]  = c.eifs_ticks;
    vals[REG_CWMIN] = CFG_DATA_BITS'(c.cw_min);
    vals[REG_CWMAX] = CFG_DATA_BITS'(c.cw_max);
    vals[REG_SLOT]  = CFG_DATA_BITS'(c.slot_ticks);
    for (int i = 0; i <= int'(REG_SLOT); i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_BITS'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(CFG_INDEX_BITS'(i), vals[i]);
    end
    junk = CFG_DATA_BITS'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_wdata <= junk;
    @(posedge clk);
    sb.set_reg(REG_UNUSED, junk);
    cfg_write <= 1'b0;
  endtask

  // Stimulus: directed opening, then random phases over several settings.
  initial begin
    cfg_t c;
    req_t r;
    int   counted;
    int   target;
    bit   held;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with short spaces and a small window.
    c = '{ifs_ticks: 16'd2, eifs_ticks: 16'd5, cw_min: 10'd3, cw_max: 10'd7, slot_ticks: 12'd2};
    write_config(c);
    send_gap_pct = 20;
    stall_pct = 20;
    send_request(make_req(CMD_RESERVED_LO, 1'b1, 4'd15, 10'h3FF, 1'b1));
    // Start on a busy medium defers with no slots drawn.
    send_request(make_req(CMD_START, 1'b0, 4'd0, 10'd0, 1'b0));
    send_request(make_req(CMD_MEDIUM, 1'b1, 4'd0, 10'd0, 1'b0));
    send_request(make_req(CMD_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
    // Zero slots: this tick goes straight to transmit.
    send_request(make_req(CMD_TICK, 1'b1, 4'd15, 10'h3FF, 1'b1));
    send_request(make_req(CMD_TX_DONE, 1'b0, 4'd0, 10'd0, 1'b0));
    send_request(make_req(CMD_TX_DONE, 1'b1, 4'd15, 10'h3FF, 1'b1));
    // A bad FCS arms the extended space for the next start.
    send_request(make_req(CMD_FRAME_RX, 1'b1, 4'd0, 10'd0, 1'b0));
    send_request(make_req(CMD_START, 1'b1, 4'd15, 10'h3FF, 1'b0));
    send_request(make_req(CMD_START, 1'b0, 4'd0, 10'h3FF, 1'b1));
    repeat (5) send_request(make_req(CMD_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
    // Busy in backoff keeps full slots only, and the extended space is not cancelled.
    send_request(make_req(CMD_MEDIUM, 1'b0, 4'd0, 10'd0, 1'b0));
    send_request(make_req(CMD_FRAME_RX, 1'b0, 4'd0, 10'd0, 1'b0));
    send_request(make_req(CMD_MEDIUM, 1'b1, 4'd0, 10'd0, 1'b0));
    send_request(make_req(CMD_FRAME_RX, 1'b0, 4'd0, 10'd0, 1'b1));
    send_request(make_req(CMD_RESERVED_HI, 1'b0, 4'd0, 10'd0, 1'b0));
    repeat (5) send_request(make_req(CMD_TICK, 1'b1, 4'd0, 10'd0, 1'b0));

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: c = '{ifs_ticks: 16'd0, eifs_ticks: 16'd0, cw_min: 10'd1, cw_max: 10'd1,
                 slot_ticks: 12'd1};
        1: c = '{ifs_ticks: 16'd3, eifs_ticks: 16'd10, cw_min: 10'd3, cw_max: 10'd31,
                 slot_ticks: 12'd3};
        2: begin
          // Minimum window above the maximum: the maximum wins.
          c.ifs_ticks  = IFS_BITS'($urandom_range(0, 20));
          c.eifs_ticks = IFS_BITS'($urandom_range(0, 40));
          c.cw_min     = 10'd7;
          c.cw_max     = 10'd3;
          c.slot_ticks = SLOT_BITS'($urandom_range(1, 6));
        end
        3: c = '{ifs_ticks: 16'd4, eifs_ticks: 16'd9, cw_min: 10'd5, cw_max: 10'd12,
                 slot_ticks: 12'd2};
        4: c = '{ifs_ticks: 16'hFFFF, eifs_ticks: 16'hFFFF, cw_min: 10'h3FF, cw_max: 10'h3FF,
                 slot_ticks: 12'hFFF};
        5: c = '{ifs_ticks: 16'hFFFF, eifs_ticks: 16'd1, cw_min: 10'd1, cw_max: 10'd1,
                 slot_ticks: 12'd1};
        default: begin
          c.ifs_ticks  = IFS_BITS'($urandom_range(0, 30));
          c.eifs_ticks = IFS_BITS'($urandom_range(0, 60));
          c.cw_min     = CW_BITS'((1 << $urandom_range(1, 5)) - 1);
          c.cw_max     = CW_BITS'((1 << $urandom_range(1, 6)) - 1);
          c.slot_ticks = SLOT_BITS'($urandom_range(1, 8));
        end
      endcase
      write_config(c);
      if (p == 3 || p == 5 || p == PHASES - 1) begin
        send_gap_pct = 0;
        stall_pct = 0;
      end else begin
        send_gap_pct = $urandom_range(5, 30);
        stall_pct = $urandom_range(5, 30);
      end

      if (p == 5) begin
        // Free medium with the longest space: a start has to wait out the idle shortfall.
        send_request(make_req(CMD_MEDIUM, 1'b1, RETRY_BITS'($urandom), CW_BITS'($urandom),
                              1'($urandom_range(0, 1))));
        repeat (HIGH_REQS)
          send_request(make_req(CMD_TICK, 1'($urandom_range(0, 1)), RETRY_BITS'($urandom),
                                CW_BITS'($urandom), 1'($urandom_range(0, 1))));
        send_request(make_req(CMD_TICK, 1'b0, 4'd0, 10'd0, 1'b0));
        send_request(make_req(CMD_FRAME_RX, 1'b1, 4'd0, 10'd0, 1'b0));
        send_request(make_req(CMD_START, 1'b1, RETRY_BITS'($urandom), CW_BITS'($urandom),
                              1'b1));
        send_request(make_req(CMD_TX_DONE, 1'b0, 4'd0, 10'd0, 1'b0));
      end else begin
        counted = 0;
        held = 1'b0;
        target = (p == 4) ? HIGH_REQS : PHASE_REQS;
        while (counted < target) begin
          if (p == 1 && !held && counted == PHASE_REQS / 2) begin
            drain_results();
            held = 1'b1;
          end
          r = pick_request();
          // Requests the engine ignores do not count.
          if (!(r.command > CMD_FRAME_RX ||
                (r.command == CMD_START && sb.st != ST_IDLE) ||
                (r.command == CMD_TX_DONE && sb.st != ST_TRANSMIT)))
            counted++;
          send_request(r);
        end
      end
    end

    drain_results();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS dcf_contention_backoff_core");
    end else begin
      $display("FAIL dcf_contention_backoff_core");
    end
    $finish;
  end

endmodule
